[src/b62_pkg.sv]
// ----------------------------------------------------------------------------
// b62_pkg
// Shared types, sizes and the character-to-digit map for the base-62 decoder.
// ----------------------------------------------------------------------------
package b62_pkg;

  localparam int MAX_CHARS = 10;             // longest string that decodes
  localparam int CODE_W    = 7;
  localparam int DIGIT_W   = 6;
  localparam int VALUE_W   = 60;
  localparam int CNT_W     = 4;              // holds MAX_CHARS + 1
  localparam int TDATA_IN_W  = 8;
  localparam int TDATA_OUT_W = 64;

  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_CHARS);
  localparam logic [CNT_W-1:0] CNT_OVER = CNT_W'(MAX_CHARS + 1);

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_TOO_LONG = 1'b1;

  // One character after the alphabet lookup.
  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               last;
  } char_t;

  // Position of a character in the shuffled alphabet; anything else is 0.
  function automatic logic [DIGIT_W-1:0] char_to_digit(input logic [CODE_W-1:0] code);
    logic [7:0] c;
    logic [DIGIT_W-1:0] d;
    c = {1'b0, code};
    unique case (c)
      "W": d = 6'd0;   "n": d = 6'd1;   "l": d = 6'd2;   "V": d = 6'd3;
      "9": d = 6'd4;   "k": d = 6'd5;   "u": d = 6'd6;   "B": d = 6'd7;
      "F": d = 6'd8;   "4": d = 6'd9;   "a": d = 6'd10;  "X": d = 6'd11;
      "x": d = 6'd12;  "Y": d = 6'd13;  "c": d = 6'd14;  "R": d = 6'd15;
      "o": d = 6'd16;  "f": d = 6'd17;  "A": d = 6'd18;  "Q": d = 6'd19;
      "S": d = 6'd20;  "3": d = 6'd21;  "I": d = 6'd22;  "m": d = 6'd23;
      "T": d = 6'd24;  "p": d = 6'd25;  "H": d = 6'd26;  "7": d = 6'd27;
      "P": d = 6'd28;  "b": d = 6'd29;  "0": d = 6'd30;  "N": d = 6'd31;
      "G": d = 6'd32;  "w": d = 6'd33;  "L": d = 6'd34;  "Z": d = 6'd35;
      "e": d = 6'd36;  "g": d = 6'd37;  "K": d = 6'd38;  "1": d = 6'd39;
      "2": d = 6'd40;  "v": d = 6'd41;  "r": d = 6'd42;  "6": d = 6'd43;
      "O": d = 6'd44;  "i": d = 6'd45;  "d": d = 6'd46;  "5": d = 6'd47;
      "E": d = 6'd48;  "D": d = 6'd49;  "z": d = 6'd50;  "J": d = 6'd51;
      "s": d = 6'd52;  "y": d = 6'd53;  "q": d = 6'd54;  "t": d = 6'd55;
      "U": d = 6'd56;  "8": d = 6'd57;  "h": d = 6'd58;  "C": d = 6'd59;
      "M": d = 6'd60;  "j": d = 6'd61;
      default: d = '0;
    endcase
    return d;
  endfunction

endpackage

[src/b62_char_map.sv]
// ----------------------------------------------------------------------------
// b62_char_map
// Input stage: maps a character to its digit and holds it for the accumulator.
// ----------------------------------------------------------------------------
module b62_char_map (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,     // input transfer this cycle
  input  logic                       consume,  // accumulator takes the held char
  input  logic [b62_pkg::CODE_W-1:0] code,
  input  logic                       last,
  output logic                       valid,
  output b62_pkg::char_t             chr
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (consume) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      chr.digit <= b62_pkg::char_to_digit(code);
      chr.last  <= last;
    end
  end

endmodule

[src/base62_string_decoder_unit.sv]
// ----------------------------------------------------------------------------
// base62_string_decoder_unit
// Streaming decoder of short-link strings in a shuffled base-62 alphabet.
// ----------------------------------------------------------------------------
// Usage:
//   Feed the string one character per transfer on the s_ channel, first
//   (most significant) character first, with s_tlast on the final character.
//   Characters outside the alphabet count as digit 0 but still add to the
//   length. Each string yields one transfer on the m_ channel: the decoded
//   value in m_tdata and the status in m_tuser (0 decoded, 1 the string was
//   longer than the maximum length, value then 0).
// Timing:
//   One character per cycle while no last character waits for the output
//   register (see Stall). A character is mapped to its digit as it enters
//   the input register, then folded into the running value (value * 62 +
//   digit, built from two shifts and a subtract) as it leaves it; a last
//   character leaving it loads the folded value into the result register.
// Reset:
//   rst (synchronous) empties both stages and clears the running value and
//   the character count.
// Stall:
//   While m_tready is low a waiting result is held; characters that end no
//   string keep flowing, and a last character waits in the input stage until
//   the output register frees up.
// ----------------------------------------------------------------------------
module base62_string_decoder_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [b62_pkg::TDATA_IN_W-1:0]   s_tdata,   // [6:0] char_code, [7] zero
  input  logic                             s_tlast,   // last_char
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [b62_pkg::TDATA_OUT_W-1:0]  m_tdata,   // [59:0] value, [63:60] zero
  output logic                             m_tuser    // status
);

  logic                 in_valid;
  b62_pkg::char_t       in_chr;
  logic                 load;
  logic                 consume;
  logic                 out_free;

  logic [b62_pkg::VALUE_W-1:0] running_value;
  logic [b62_pkg::VALUE_W-1:0] running_value_next;
  logic [b62_pkg::CNT_W-1:0]   char_count;
  logic [b62_pkg::CNT_W-1:0]   char_count_next;
  logic [b62_pkg::VALUE_W-1:0] value;
  logic                        status;

  // Output slot is free when empty or being drained this cycle.
  assign out_free = !m_tvalid || m_tready;
  // A last character needs the output slot; others only touch the state.
  assign consume  = in_valid && (!in_chr.last || out_free);
  assign s_tready = !in_valid || consume;
  assign load     = s_tvalid && s_tready;

  b62_char_map u_char_map (
    .clk     (clk),
    .rst     (rst),
    .load    (load),
    .consume (consume),
    .code    (s_tdata[b62_pkg::CODE_W-1:0]),
    .last    (s_tlast),
    .valid   (in_valid),
    .chr     (in_chr)
  );

  // Horner step: value * 62 = (value << 6) - (value << 1). Stop accumulating
  // once the count reaches the limit and pin the count one past it.
  always_comb begin
    running_value_next = running_value;
    char_count_next    = char_count;
    if (char_count < b62_pkg::CNT_MAX) begin
      running_value_next = (running_value << 6) - (running_value << 1)
                           + b62_pkg::VALUE_W'(in_chr.digit);
      char_count_next    = char_count + 1'b1;
    end else begin
      char_count_next    = b62_pkg::CNT_OVER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_value <= '0;
      char_count    <= '0;
    end else if (consume) begin
      if (in_chr.last) begin
        running_value <= '0;
        char_count    <= '0;
      end else begin
        running_value <= running_value_next;
        char_count    <= char_count_next;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (consume && in_chr.last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && in_chr.last) begin
      if (char_count_next > b62_pkg::CNT_MAX) begin
        value  <= '0;
        status <= b62_pkg::STATUS_TOO_LONG;
      end else begin
        value  <= running_value_next;
        status <= b62_pkg::STATUS_OK;
      end
    end
  end

  assign m_tdata = b62_pkg::TDATA_OUT_W'(value);
  assign m_tuser = status;

endmodule
